// ===== design/lrcm_pkg.sv =====
// shared types, constants and helpers of the learning remote code matcher
`default_nettype none

package lrcm_pkg;

    localparam int CODE_W = 24;
    localparam int MASK_W = 16;
    localparam int CFG_W  = 8;
    localparam int OUT_W  = 24;

    localparam logic [CODE_W-1:0] CODE_ERASED = 24'hFFFFFF;
    localparam logic [CODE_W-1:0] CODE_BLANK  = 24'h000000;

    localparam logic       HOLD_EN_RST = 1'b1;
    localparam logic [7:0] HOLD_TO_RST = 8'd50;

    typedef enum logic [1:0] {
        KIND_RECV  = 2'd0,
        KIND_LEARN = 2'd1,
        KIND_ERASE = 2'd2,
        KIND_TICK  = 2'd3
    } t_kind;

    typedef enum logic {
        REG_HOLD_EN = 1'b0,
        REG_HOLD_TO = 1'b1
    } t_reg;

    // control from the sequencer to the code table
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic erase;
    } t_tbl_ctl;

    function automatic logic lrcm_is_stored(input logic [CODE_W-1:0] code);
        return (code != CODE_BLANK) && (code != CODE_ERASED);
    endfunction

endpackage

`default_nettype wire

// ===== design/lrcm_table.sv =====
// learned code table: synchronous memory with per-entry valid and stored flags
`default_nettype none

module lrcm_table
    import lrcm_pkg::*;
#(
    parameter int ENTRIES = 16,
    parameter int AW      = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_tbl_ctl          i_ctl,
    input  wire logic [AW-1:0]     i_rd_addr,
    input  wire logic [AW-1:0]     i_wr_addr,
    input  wire logic [CODE_W-1:0] i_wr_code,
    output logic [CODE_W-1:0]      o_rd_code,
    output logic                   o_any_stored
);

    logic [CODE_W-1:0]  r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_vld;
    logic [ENTRIES-1:0] r_sto;
    logic [CODE_W-1:0]  r_rd_data;
    logic               r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_code;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // an entry never written since reset or erase reads as erased
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_sto    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.erase) begin
                r_vld <= '0;
                r_sto <= '0;
            end else if (i_ctl.wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
                r_sto[i_wr_addr] <= lrcm_is_stored(i_wr_code);
            end
            if (i_ctl.rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_code    = r_rd_vld ? r_rd_data : CODE_ERASED;
    assign o_any_stored = |r_sto;

endmodule

`default_nettype wire

// ===== design/learning_remote_code_matcher_core.sv =====
// top level of the learning remote code matcher: sequencer, hold tracking, ports
`default_nettype none

// Keeps REMOTES x CHANNELS learned 24-bit codes in a synchronous table with one
// read and one write port and answers one result item per input item. The table
// memory has one read per cycle, so a receive walks all entries before the next
// item is taken. A learn moves each remote's slots back by CHANNELS entries,
// reading and writing in the same cycle, drops the last remote and writes the code
// into entry 0. Erase, tick and a receive during a held press skip the scan and
// go to the finish step. Erase clears all per-entry valid flags together, so there
// is no clearing pass after reset. Results wait in an output register; while one
// is still waiting the next result holds the sequencer in its finish step, and a
// new item is taken only when the sequencer is idle. Configuration writes are
// taken at any time and should be issued only while no item is in flight.
module learning_remote_code_matcher_core
    import lrcm_pkg::*;
#(
    parameter int REMOTES  = 4,
    parameter int CHANNELS = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [CODE_W-1:0] i_s_tdata,   // [23:0] code_word
    input  wire logic [1:0]        i_s_tuser,   // [1:0] kind
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [OUT_W-1:0]       o_m_tdata,   // [0] matched, [16:1] match_mask,
                                                // [17] held, [18] any_stored, zero above
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic              i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data
);

    localparam int ENTRIES = REMOTES * CHANNELS;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW      = $clog2(ENTRIES + 1);
    localparam int NCOPY   = ENTRIES - CHANNELS;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RECV  = 4'b0010,
        ST_LEARN = 4'b0100,
        ST_FIN   = 4'b1000
    } t_state;

    t_state             r_state,     n_state;
    logic [CW-1:0]      r_cnt,       n_cnt;
    logic               r_pend,      n_pend;
    logic [AW-1:0]      r_paddr,     n_paddr;
    logic [CODE_W-1:0]  r_code,      n_code;
    logic               r_hit,       n_hit;
    logic [MASK_W-1:0]  r_mask,      n_mask;
    logic               r_matched,   n_matched;
    logic [MASK_W-1:0]  r_last_mask, n_last_mask;
    logic               r_hold_flag, n_hold_flag;
    logic [7:0]         r_hold_cnt,  n_hold_cnt;
    logic               r_hold_en;
    logic [7:0]         r_hold_to;
    logic               r_o_valid,   n_o_valid;
    logic [OUT_W-1:0]   r_o_data,    n_o_data;

    t_tbl_ctl           tbl_ctl;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [CODE_W-1:0]  wr_code;
    logic [CODE_W-1:0]  rd_code;
    logic               any_stored;
    logic               s_accept;
    logic               cmp_eq;
    logic [CW-1:0]      cnt_m1;
    t_kind              in_kind;

    lrcm_table #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (tbl_ctl),
        .i_rd_addr    (rd_addr),
        .i_wr_addr    (wr_addr),
        .i_wr_code    (wr_code),
        .o_rd_code    (rd_code),
        .o_any_stored (any_stored)
    );

    assign o_s_tready  = (r_state == ST_IDLE);
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign in_kind     = t_kind'(i_s_tuser);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_o_valid;
    assign o_m_tdata   = r_o_data;
    assign cmp_eq      = (rd_code == r_code);
    assign cnt_m1      = r_cnt - CW'(1);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pend      = 1'b0;
        n_paddr     = r_paddr;
        n_code      = r_code;
        n_hit       = r_hit;
        n_mask      = r_mask;
        n_matched   = r_matched;
        n_last_mask = r_last_mask;
        n_hold_flag = r_hold_flag;
        n_hold_cnt  = r_hold_cnt;
        n_o_valid   = r_o_valid && !i_m_tready;
        n_o_data    = r_o_data;
        tbl_ctl     = '0;
        rd_addr     = r_cnt[AW-1:0];
        wr_addr     = AW'(r_paddr + AW'(CHANNELS));
        wr_code     = rd_code;

        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_code    = i_s_tdata;
                    n_matched = 1'b0;
                    n_state   = ST_FIN;
                    case (in_kind)
                        KIND_RECV: begin
                            n_hold_cnt = '0;
                            if (!(r_hold_en && r_hold_flag)) begin
                                n_cnt   = '0;
                                n_hit   = 1'b0;
                                n_mask  = '0;
                                n_state = ST_RECV;
                            end
                        end
                        KIND_LEARN: begin
                            n_cnt   = CW'(NCOPY);
                            n_state = ST_LEARN;
                        end
                        KIND_ERASE: begin
                            tbl_ctl.erase = 1'b1;
                        end
                        default: begin
                            if (!r_hold_en) begin
                                n_hold_flag = 1'b0;
                                n_hold_cnt  = '0;
                            end else if (r_hold_flag) begin
                                if (r_hold_cnt >= r_hold_to) begin
                                    n_hold_flag = 1'b0;
                                    n_hold_cnt  = '0;
                                end else begin
                                    n_hold_cnt = r_hold_cnt + 8'd1;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_RECV: begin
                // issue one read per cycle, compare it in the cycle after
                if (r_cnt != CW'(ENTRIES)) begin
                    tbl_ctl.rd_en = 1'b1;
                    n_pend        = 1'b1;
                    n_paddr       = r_cnt[AW-1:0];
                    n_cnt         = r_cnt + CW'(1);
                end
                if (r_pend) begin
                    // entries past the mask width still count as a hit
                    n_hit = r_hit | cmp_eq;
                    if (cmp_eq) begin
                        n_mask = r_mask | (MASK_W'(1) << r_paddr);
                    end
                    if (r_paddr == AW'(ENTRIES - 1)) begin
                        n_last_mask = n_mask;
                        n_matched   = n_hit;
                        n_hold_flag = r_hold_en && n_hit;
                        n_state     = ST_FIN;
                    end
                end
            end
            ST_LEARN: begin
                // copy slots back from the top, then drop the code into entry 0
                rd_addr = cnt_m1[AW-1:0];
                if (r_cnt != '0) begin
                    tbl_ctl.rd_en = 1'b1;
                    n_pend        = 1'b1;
                    n_paddr       = cnt_m1[AW-1:0];
                    n_cnt         = cnt_m1;
                end
                if (r_pend) begin
                    tbl_ctl.wr_en = 1'b1;
                end else if (r_cnt == '0) begin
                    tbl_ctl.wr_en = 1'b1;
                    wr_addr       = '0;
                    wr_code       = r_code;
                    n_state       = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_o_valid || i_m_tready) begin
                    n_o_valid = 1'b1;
                    n_o_data  = OUT_W'({any_stored, r_hold_flag, r_last_mask, r_matched});
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_mask      <= '0;
            r_matched   <= 1'b0;
            r_last_mask <= '0;
            r_hold_flag <= 1'b0;
            r_hold_cnt  <= '0;
            r_hold_en   <= HOLD_EN_RST;
            r_hold_to   <= HOLD_TO_RST;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_hit       <= n_hit;
            r_mask      <= n_mask;
            r_matched   <= n_matched;
            r_last_mask <= n_last_mask;
            r_hold_flag <= n_hold_flag;
            r_hold_cnt  <= n_hold_cnt;
            r_o_valid   <= n_o_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_reg'(i_cfg_index))
                    REG_HOLD_EN: r_hold_en <= i_cfg_data[0];
                    REG_HOLD_TO: r_hold_to <= i_cfg_data;
                    default:     r_hold_en <= r_hold_en;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_paddr  <= n_paddr;
        r_code   <= n_code;
        r_o_data <= n_o_data;
    end

`ifndef SYNTHESIS
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RECV) |-> !tbl_ctl.wr_en)
        else $error("table written during a receive scan");

    a_erase_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && (in_kind == KIND_ERASE)) |=> !any_stored)
        else $error("stored flags survive an erase");

    a_held_keeps_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && (in_kind == KIND_RECV) && r_hold_en && r_hold_flag)
        |=> $stable(r_last_mask) && (r_state == ST_FIN))
        else $error("held receive changed the mask or started a scan");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == ST_FIN))
        else $error("result item raised outside the finish step");
`endif

endmodule

`default_nettype wire
